// File: rtl/ids_pkg.sv
// shared types and constants for the indexed deque store
// no dependencies
`default_nettype none

package ids_pkg;

    localparam int DEFAULT_DEPTH      = 16;
    localparam int DEFAULT_DATA_WIDTH = 32;
    localparam int ENTRY_W            = 32;
    localparam int RESULT_W           = 32;
    localparam int POS_W              = 6;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_SET    = 2'd2,
        CMD_READ   = 2'd3
    } t_command;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_MISSING = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_INS  = 2'd1,
        CELL_REM  = 2'd2,
        CELL_SET  = 2'd3
    } t_cell_op;

endpackage

`default_nettype wire

// File: rtl/ids_cell.sv
// one storage cell of the deque row: holds a word, shifts with its neighbors
// depends on ids_pkg
`default_nettype none

module ids_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int IDX_W      = 4,
    parameter int CELL_IDX   = 0
) (
    input  wire                   i_clk,
    input  ids_pkg::t_cell_op     i_op,
    input  wire [IDX_W-1:0]       i_at,
    input  wire [DATA_WIDTH-1:0]  i_word,
    input  wire [DATA_WIDTH-1:0]  i_left,
    input  wire [DATA_WIDTH-1:0]  i_right,
    output logic [DATA_WIDTH-1:0] o_value
);
    import ids_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic [DATA_WIDTH-1:0] r_value;
    logic [DATA_WIDTH-1:0] n_value;

    always_comb begin
        n_value = r_value;
        unique case (i_op)
            CELL_HOLD: n_value = r_value;
            CELL_INS: begin
                if (MY_IDX == i_at) begin
                    n_value = i_word;
                end else if (MY_IDX > i_at) begin
                    n_value = i_left;
                end
            end
            CELL_REM: begin
                if (MY_IDX >= i_at) begin
                    n_value = i_right;
                end
            end
            CELL_SET: begin
                if (MY_IDX == i_at) begin
                    n_value = i_word;
                end
            end
            default: n_value = r_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

`default_nettype wire

// File: rtl/indexed_deque_store.sv
// Indexed deque store: an ordered list of up to DEPTH words kept in a row of cells that
// all shift or load together, so every command (insert, remove, overwrite, read) acts
// on all cells at once and one word is accepted per cycle while o_stall is low; the result
// sits in an output register and o_stall rises only while that register is full and stalled.
// Negative positions count from the tail (-1 appends, -2 names the last entry). Storage
// is not cleared by reset; only the entry count and the output valid flag are.
`default_nettype none

module indexed_deque_store #(
    parameter int DEPTH      = ids_pkg::DEFAULT_DEPTH,
    parameter int DATA_WIDTH = ids_pkg::DEFAULT_DATA_WIDTH,
    localparam int CNT_W     = $clog2(DEPTH + 1)
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_stall,
    input  wire [1:0]                    i_command,
    input  wire signed [ids_pkg::POS_W-1:0] i_position,
    input  wire [ids_pkg::ENTRY_W-1:0]   i_entry_value,
    output logic                         o_valid,
    input  wire                          i_stall,
    output logic [ids_pkg::RESULT_W-1:0] o_result_value,
    output logic [1:0]                   o_status,
    output logic [CNT_W-1:0]             o_occupancy
);
    import ids_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RES_W = (CNT_W + 2 > POS_W + 1) ? CNT_W + 2 : POS_W + 1;

    logic                  r_out_valid;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic [RESULT_W-1:0]   r_result;
    logic [RESULT_W-1:0]   n_result;
    t_status               r_status;
    t_status               n_status;

    logic                  accept;
    logic                  full;
    logic                  hit;
    logic signed [RES_W-1:0] pos_ext;
    logic signed [RES_W-1:0] cnt_ext;
    logic signed [RES_W-1:0] resolved;
    logic [IDX_W-1:0]      idx;
    logic [IDX_W-1:0]      at;
    logic [DATA_WIDTH-1:0] word;
    logic [DATA_WIDTH-1:0] rd_value;
    t_command              cmd;
    t_cell_op              op;
    t_cell_op              cell_op;
    logic [DATA_WIDTH-1:0] cell_val [DEPTH];

    assign o_stall = r_out_valid & i_stall;
    assign accept  = i_valid & ~o_stall;
    assign full    = (r_count == CNT_W'(DEPTH));
    assign cmd     = t_command'(i_command);
    assign word    = DATA_WIDTH'(i_entry_value);

    // position resolution
    assign pos_ext  = RES_W'(i_position);
    assign cnt_ext  = $signed(RES_W'(r_count));
    assign resolved = (pos_ext < 0) ? pos_ext + cnt_ext + RES_W'(1) : pos_ext;
    assign hit      = (resolved >= 0) && (resolved < cnt_ext);
    assign idx      = resolved[IDX_W-1:0];
    assign rd_value = cell_val[idx];

    always_comb begin
        op       = CELL_HOLD;
        at       = idx;
        n_count  = r_count;
        n_status = ST_DONE;
        n_result = '0;
        unique case (cmd)
            CMD_INSERT: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    op      = CELL_INS;
                    at      = hit ? idx : r_count[IDX_W-1:0];
                    n_count = r_count + CNT_W'(1);
                end
            end
            CMD_REMOVE: begin
                if (!hit) begin
                    n_status = ST_MISSING;
                end else begin
                    op       = CELL_REM;
                    n_result = RESULT_W'(rd_value);
                    n_count  = r_count - CNT_W'(1);
                end
            end
            CMD_SET: begin
                if (!hit) begin
                    n_status = ST_MISSING;
                end else begin
                    op = CELL_SET;
                end
            end
            CMD_READ: begin
                if (!hit) begin
                    n_status = ST_MISSING;
                end else begin
                    n_result = RESULT_W'(rd_value);
                end
            end
            default: n_status = ST_DONE;
        endcase
    end

    assign cell_op = accept ? op : CELL_HOLD;

    // row of cells
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] left_val;
        logic [DATA_WIDTH-1:0] right_val;
        if (g == 0) begin : g_first
            assign left_val = word;
        end else begin : g_mid_l
            assign left_val = cell_val[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign right_val = cell_val[g];
        end else begin : g_mid_r
            assign right_val = cell_val[g+1];
        end
        ids_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .IDX_W      (IDX_W),
            .CELL_IDX   (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_op    (cell_op),
            .i_at    (at),
            .i_word  (word),
            .i_left  (left_val),
            .i_right (right_val),
            .o_value (cell_val[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            if (accept) begin
                r_out_valid <= 1'b1;
                r_count     <= n_count;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= n_result;
            r_status <= n_status;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_result_value = r_result;
    assign o_status       = r_status;
    assign o_occupancy    = r_count;

endmodule

`default_nettype wire

// File: rtl/ids_checker.sv
// port-level assertions for the indexed deque store, bound to the top level
// depends on ids_pkg and indexed_deque_store
`default_nettype none

module ids_props #(
    parameter int DEPTH      = ids_pkg::DEFAULT_DEPTH,
    localparam int CNT_W     = $clog2(DEPTH + 1)
) (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          i_out_valid,
    input wire                          i_out_stall,
    input wire [ids_pkg::RESULT_W-1:0]  i_result_value,
    input wire [1:0]                    i_status,
    input wire [CNT_W-1:0]              i_occupancy
);
    import ids_pkg::*;

    // stalled word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_result_value)
            && $stable(i_status) && $stable(i_occupancy))
        else $error("stalled result word changed");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status != ST_DONE) |-> (i_result_value == '0))
        else $error("nonzero value with failing status");

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_occupancy <= CNT_W'(DEPTH)))
        else $error("occupancy above depth");

    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ST_FULL) |-> (i_occupancy == CNT_W'(DEPTH)))
        else $error("full status while not full");

endmodule

bind indexed_deque_store ids_props #(
    .DEPTH (DEPTH)
) u_ids_props (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_valid),
    .i_out_stall    (i_stall),
    .i_result_value (o_result_value),
    .i_status       (o_status),
    .i_occupancy    (o_occupancy)
);

`default_nettype wire
